>>> design/x86_prefix_decoder_top_defines.svh
// Assertion macros shared by the x86 prefix decoder RTL.
// They refer to the signals clk and arst_n of the module that includes this file.
`ifndef X86_PREFIX_DECODER_TOP_DEFINES_SVH
`define X86_PREFIX_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/xpd_pkg.sv
// Types, codes and byte constants of the x86 prefix decoder.
// Used by xpd_step and x86_prefix_decoder_top; depends on nothing.
`default_nettype none

package xpd_pkg;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_LEGACY,
		PH_VEX2_D,
		PH_VEX3_D1,
		PH_VEX3_D2,
		PH_VEX_OP,
		PH_EVEX_D1,
		PH_EVEX_D2,
		PH_EVEX_D3,
		PH_EVEX_OP,
		PH_SKIP
	} xpd_phase_t;

	typedef struct packed {
		logic [4:0] mask;
		logic [3:0] len_pp;
		logic [4:0] vreg;
		logic [4:0] map;
	} xpd_vec_t;

	typedef struct packed {
		xpd_phase_t phase;
		logic [1:0] lock_rep;
		logic [2:0] seg;
		logic [1:0] size;
		logic [5:0] ext;
		xpd_vec_t   vec;
		logic [2:0] perr;
	} xpd_state_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] opcode;
		logic [1:0] kind;
		logic [1:0] lock_rep;
		logic [2:0] seg;
		logic       opsz;
		logic       adsz;
		logic [4:0] ext;
		logic [4:0] map;
		logic [4:0] vreg;
		logic [3:0] len_pp;
		logic [4:0] mask;
	} xpd_result_t;

	localparam xpd_state_t XPD_STATE_RESET = '0;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ENDED    = 3'd1;
	localparam logic [2:0] ST_VEX_INC  = 3'd2;
	localparam logic [2:0] ST_EVEX_INC = 3'd3;
	localparam logic [2:0] ST_EVEX_B1  = 3'd4;
	localparam logic [2:0] ST_EVEX_B2  = 3'd5;
	localparam logic [2:0] ST_DUP_LR   = 3'd6;
	localparam logic [2:0] ST_DUP_REX  = 3'd7;

	localparam logic [1:0] KIND_LEGACY = 2'd0;
	localparam logic [1:0] KIND_REX    = 2'd1;
	localparam logic [1:0] KIND_VEX    = 2'd2;
	localparam logic [1:0] KIND_EVEX   = 2'd3;

	localparam logic [1:0] LR_LOCK  = 2'd1;
	localparam logic [1:0] LR_REPNE = 2'd2;
	localparam logic [1:0] LR_REP   = 2'd3;

	localparam logic [2:0] SEG_NONE = 3'd0;
	localparam logic [2:0] SEG_CS   = 3'd1;
	localparam logic [2:0] SEG_SS   = 3'd2;
	localparam logic [2:0] SEG_DS   = 3'd3;
	localparam logic [2:0] SEG_ES   = 3'd4;
	localparam logic [2:0] SEG_FS   = 3'd5;
	localparam logic [2:0] SEG_GS   = 3'd6;

	localparam logic [7:0] BYTE_LOCK  = 8'hF0;
	localparam logic [7:0] BYTE_REPNE = 8'hF2;
	localparam logic [7:0] BYTE_REP   = 8'hF3;
	localparam logic [7:0] BYTE_OPSZ  = 8'h66;
	localparam logic [7:0] BYTE_ADSZ  = 8'h67;
	localparam logic [7:0] BYTE_VEX2  = 8'hC5;
	localparam logic [7:0] BYTE_VEX3  = 8'hC4;
	localparam logic [7:0] BYTE_EVEX  = 8'h62;
	localparam logic [7:0] BYTE_CS    = 8'h2E;
	localparam logic [7:0] BYTE_SS    = 8'h36;
	localparam logic [7:0] BYTE_DS    = 8'h3E;
	localparam logic [7:0] BYTE_ES    = 8'h26;
	localparam logic [7:0] BYTE_FS    = 8'h64;
	localparam logic [7:0] BYTE_GS    = 8'h65;
	localparam logic [7:0] REX_MASK   = 8'hF0;
	localparam logic [7:0] REX_BASE   = 8'h40;

	function automatic logic [2:0] seg_code(input logic [7:0] b);
		logic [2:0] code;
		case (b)
			BYTE_CS: code = SEG_CS;
			BYTE_SS: code = SEG_SS;
			BYTE_DS: code = SEG_DS;
			BYTE_ES: code = SEG_ES;
			BYTE_FS: code = SEG_FS;
			BYTE_GS: code = SEG_GS;
			default: code = SEG_NONE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> design/x86_prefix_decoder_top.sv
// Top level of the x86 prefix decoder: input register, decode step, result register.
// Depends on xpd_pkg, xpd_step and x86_prefix_decoder_top_defines.svh.
// The block takes one instruction byte per beat and one byte per cycle while the output is not
// stalled. A byte goes into an input register at its accepting edge and is decoded from there against
// the held prefix state; the result register loads when the decode stage advances and offers the result.
// The decode stage waits only while the result register holds a beat that is stalled.
// At most one result is given per instruction, at the opcode byte, at an error or at the byte
// marked last; after an earlier result, bytes are dropped up to the one marked last.
`default_nettype none

`include "x86_prefix_decoder_top_defines.svh"

module x86_prefix_decoder_top import xpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] opcode_byte,
	output logic [1:0] encoding_kind,
	output logic [1:0] lock_rep_prefix,
	output logic [2:0] segment_prefix,
	output logic       operand_size_flag,
	output logic       address_size_flag,
	output logic [4:0] extension_bits,
	output logic [4:0] opcode_map,
	output logic [4:0] register_specifier,
	output logic [3:0] length_and_prefix,
	output logic [4:0] evex_mask_bits
);

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        in_take;
	logic        emit;
	xpd_state_t  state_q;
	xpd_state_t  state_d;
	xpd_result_t res;
	xpd_result_t res_q;
	logic        out_vld_q;

	assign advance  = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_take || (vld_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	xpd_step u_step (
		.cur_state  (state_q),
		.cur_byte   (byte_s1),
		.is_last    (last_s1),
		.next_state (state_d),
		.emit       (emit),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= XPD_STATE_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_vld_q;
	assign status             = res_q.status;
	assign opcode_byte        = res_q.opcode;
	assign encoding_kind      = res_q.kind;
	assign lock_rep_prefix    = res_q.lock_rep;
	assign segment_prefix     = res_q.seg;
	assign operand_size_flag  = res_q.opsz;
	assign address_size_flag  = res_q.adsz;
	assign extension_bits     = res_q.ext;
	assign opcode_map         = res_q.map;
	assign register_specifier = res_q.vreg;
	assign length_and_prefix  = res_q.len_pp;
	assign evex_mask_bits     = res_q.mask;

	`XPD_ASSERT_IMP(a_skip_silent, advance && state_q.phase == PH_SKIP, !emit,
		"Result produced while skipping bytes.")
	`XPD_ASSERT_NEXT(a_last_clears,
		advance && last_s1 && (emit || state_q.phase == PH_SKIP),
		state_q == XPD_STATE_RESET, "State not cleared after the last byte.")
	`XPD_ASSERT_IMP(a_stall_has_beat, in_stall, vld_s1,
		"Input stalled with an empty input register.")
	`XPD_ASSERT_IMP(a_err_no_opcode, out_valid && status != ST_OK, opcode_byte == 8'h00,
		"Opcode byte set on an error result.")
	`XPD_ASSERT_IMP(a_evex_status, out_valid && encoding_kind != KIND_EVEX,
		status != ST_EVEX_INC && status != ST_EVEX_B1 && status != ST_EVEX_B2,
		"EVEX status on a non-EVEX result.")

endmodule

`default_nettype wire

>>> design/xpd_step.sv
// Combinational decode of one instruction byte against the held prefix state.
// Depends on xpd_pkg for the state, result and code definitions.
`default_nettype none

module xpd_step import xpd_pkg::*; (
	input  xpd_state_t  cur_state,
	input  logic [7:0]  cur_byte,
	input  logic        is_last,
	output xpd_state_t  next_state,
	output logic        emit,
	output xpd_result_t result
);

	xpd_state_t st;
	logic [2:0] seg;
	logic       take_legacy;
	logic       pfx_done;
	logic [2:0] em_status;
	logic [7:0] em_opcode;
	logic [1:0] em_kind;

	always_comb begin
		st          = cur_state;
		seg         = seg_code(cur_byte);
		take_legacy = 1'b0;
		pfx_done    = 1'b0;
		emit        = 1'b0;
		em_status   = ST_OK;
		em_opcode   = '0;
		em_kind     = KIND_LEGACY;

		case (cur_state.phase)
			PH_SKIP: begin
				if (is_last) begin
					st = XPD_STATE_RESET;
				end
			end
			PH_LEGACY: begin
				take_legacy = 1'b1;
			end
			PH_VEX2_D: begin
				st.ext            = {3'b000, cur_byte[7], 2'b11};
				st.vec.mask       = '0;
				st.vec.len_pp     = {1'b0, cur_byte[2], cur_byte[1:0]};
				st.vec.vreg       = {1'b0, cur_byte[6:3]};
				st.vec.map        = 5'd1;
				st.phase          = PH_VEX_OP;
				if (is_last) begin
					emit      = 1'b1;
					em_status = ST_ENDED;
					em_kind   = KIND_VEX;
				end
			end
			PH_VEX3_D1: begin
				st.ext     = {3'b000, cur_byte[7], cur_byte[6], cur_byte[5]};
				st.vec     = '0;
				st.vec.map = cur_byte[4:0];
				st.phase   = PH_VEX3_D2;
				if (is_last) begin
					emit      = 1'b1;
					em_status = ST_VEX_INC;
					em_kind   = KIND_VEX;
				end
			end
			PH_VEX3_D2: begin
				st.ext[4]     = st.ext[4] | cur_byte[7];
				st.vec.vreg   = st.vec.vreg | {1'b0, cur_byte[6:3]};
				st.vec.len_pp = st.vec.len_pp | {1'b0, cur_byte[2], cur_byte[1:0]};
				st.phase      = PH_VEX_OP;
				if (is_last) begin
					emit      = 1'b1;
					em_status = ST_ENDED;
					em_kind   = KIND_VEX;
				end
			end
			PH_VEX_OP: begin
				emit      = 1'b1;
				em_status = ST_OK;
				em_opcode = cur_byte;
				em_kind   = KIND_VEX;
			end
			PH_EVEX_D1: begin
				st.ext     = {2'b00, cur_byte[4], cur_byte[7], cur_byte[6], cur_byte[5]};
				st.vec     = '0;
				st.vec.map = {3'b000, cur_byte[1:0]};
				if (cur_byte[3:2] != 2'b00) begin
					st.perr = ST_EVEX_B1;
				end
				st.phase = PH_EVEX_D2;
				if (is_last) begin
					emit      = 1'b1;
					em_status = ST_EVEX_INC;
					em_kind   = KIND_EVEX;
				end
			end
			PH_EVEX_D2: begin
				st.ext[4]     = st.ext[4] | cur_byte[7];
				st.vec.vreg   = st.vec.vreg | {1'b0, cur_byte[6:3]};
				st.vec.len_pp = st.vec.len_pp | {2'b00, cur_byte[1:0]};
				if (st.perr == ST_OK && !cur_byte[2]) begin
					st.perr = ST_EVEX_B2;
				end
				st.phase = PH_EVEX_D3;
				if (is_last) begin
					emit      = 1'b1;
					em_status = ST_EVEX_INC;
					em_kind   = KIND_EVEX;
				end
			end
			PH_EVEX_D3: begin
				st.vec.vreg[4] = st.vec.vreg[4] | cur_byte[3];
				st.vec.len_pp  = st.vec.len_pp | {cur_byte[6:5], 2'b00};
				st.vec.mask    = st.vec.mask
					| {cur_byte[7], cur_byte[4], cur_byte[2:0]};
				em_kind = KIND_EVEX;
				if (st.perr != ST_OK) begin
					emit      = 1'b1;
					em_status = st.perr;
				end else begin
					st.phase = PH_EVEX_OP;
					if (is_last) begin
						emit      = 1'b1;
						em_status = ST_ENDED;
					end
				end
			end
			PH_EVEX_OP: begin
				emit      = 1'b1;
				em_status = ST_OK;
				em_opcode = cur_byte;
				em_kind   = KIND_EVEX;
			end
			default: begin
				st.phase = PH_LEAD;
				if (seg != SEG_NONE || cur_byte == BYTE_ADSZ) begin
					if (seg != SEG_NONE) begin
						st.seg = seg;
					end else begin
						st.size[1] = 1'b1;
					end
					if (is_last) begin
						emit      = 1'b1;
						em_status = ST_ENDED;
						em_kind   = KIND_LEGACY;
					end
				end else if (cur_byte == BYTE_VEX2 || cur_byte == BYTE_VEX3) begin
					st.phase = (cur_byte == BYTE_VEX2) ? PH_VEX2_D : PH_VEX3_D1;
					if (is_last) begin
						emit      = 1'b1;
						em_status = ST_VEX_INC;
						em_kind   = KIND_VEX;
					end
				end else if (cur_byte == BYTE_EVEX) begin
					st.phase = PH_EVEX_D1;
					if (is_last) begin
						emit      = 1'b1;
						em_status = ST_EVEX_INC;
						em_kind   = KIND_EVEX;
					end
				end else begin
					take_legacy = 1'b1;
				end
			end
		endcase

		if (take_legacy) begin
			st.phase = PH_LEGACY;
			if (cur_byte == BYTE_LOCK || cur_byte == BYTE_REPNE
				|| cur_byte == BYTE_REP) begin
				if (st.lock_rep != 2'b00) begin
					emit      = 1'b1;
					em_status = ST_DUP_LR;
				end else begin
					st.lock_rep = (cur_byte == BYTE_LOCK) ? LR_LOCK
						: (cur_byte == BYTE_REPNE) ? LR_REPNE : LR_REP;
					pfx_done = 1'b1;
				end
			end else if (seg != SEG_NONE) begin
				st.seg   = seg;
				pfx_done = 1'b1;
			end else if (cur_byte == BYTE_OPSZ) begin
				st.size[0] = 1'b1;
				pfx_done   = 1'b1;
			end else if (cur_byte == BYTE_ADSZ) begin
				st.size[1] = 1'b1;
				pfx_done   = 1'b1;
			end else if ((cur_byte & REX_MASK) == REX_BASE) begin
				if (st.ext[5]) begin
					emit      = 1'b1;
					em_status = ST_DUP_REX;
				end else begin
					st.ext   = {1'b1, cur_byte[3], 1'b0, cur_byte[2:0]};
					pfx_done = 1'b1;
				end
			end else begin
				emit      = 1'b1;
				em_status = ST_OK;
				em_opcode = cur_byte;
			end
			em_kind = st.ext[5] ? KIND_REX : KIND_LEGACY;
			if (pfx_done && is_last) begin
				emit      = 1'b1;
				em_status = ST_ENDED;
			end
		end

		result.status   = em_status;
		result.opcode   = em_opcode;
		result.kind     = em_kind;
		result.lock_rep = st.lock_rep;
		result.seg      = st.seg;
		result.opsz     = st.size[0];
		result.adsz     = st.size[1];
		result.ext      = st.ext[4:0];
		result.map      = st.vec.map;
		result.vreg     = st.vec.vreg;
		result.len_pp   = st.vec.len_pp;
		result.mask     = st.vec.mask;

		if (emit) begin
			next_state = XPD_STATE_RESET;
			if (!is_last) begin
				next_state.phase = PH_SKIP;
			end
		end else begin
			next_state = st;
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for x86_prefix_decoder_top: drives instruction bytes, predicts each
// prefix decode result in a local model of the decoder, and compares results field by field.
// Depends on xpd_pkg and the decoder RTL; needs no other files.
`timescale 1ns / 100ps

module tb_top;
	import xpd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 500;
	localparam int HOLD_CYCLES = 150;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] byte_value;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [7:0] opcode_byte;
	logic [1:0] encoding_kind;
	logic [1:0] lock_rep_prefix;
	logic [2:0] segment_prefix;
	logic       operand_size_flag;
	logic       address_size_flag;
	logic [4:0] extension_bits;
	logic [4:0] opcode_map;
	logic [4:0] register_specifier;
	logic [3:0] length_and_prefix;
	logic [4:0] evex_mask_bits;

	xpd_phase_t  dec_phase;
	logic [1:0]  dec_lock_rep;
	logic [2:0]  dec_seg;
	logic [1:0]  dec_size;
	logic [5:0]  dec_ext;
	xpd_vec_t    dec_vec;
	logic [2:0]  dec_perr;
	xpd_result_t prefix_results_q [$];
	xpd_result_t want;

	int  mismatch_count = 0;
	int  results_checked = 0;
	int  error_results = 0;
	int  decoded_bytes = 0;
	int  sent_bytes = 0;
	int  rx_hold_len = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;

	x86_prefix_decoder_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.byte_value        (byte_value),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.opcode_byte       (opcode_byte),
		.encoding_kind     (encoding_kind),
		.lock_rep_prefix   (lock_rep_prefix),
		.segment_prefix    (segment_prefix),
		.operand_size_flag (operand_size_flag),
		.address_size_flag (address_size_flag),
		.extension_bits    (extension_bits),
		.opcode_map        (opcode_map),
		.register_specifier(register_specifier),
		.length_and_prefix (length_and_prefix),
		.evex_mask_bits    (evex_mask_bits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [2:0] segment_of(input logic [7:0] b);
		case (b)
			BYTE_CS: return SEG_CS;
			BYTE_SS: return SEG_SS;
			BYTE_DS: return SEG_DS;
			BYTE_ES: return SEG_ES;
			BYTE_FS: return SEG_FS;
			BYTE_GS: return SEG_GS;
			default: return SEG_NONE;
		endcase
	endfunction

	function automatic logic [7:0] pick_segment_byte();
		case ($urandom_range(0, 5))
			0: return BYTE_CS;
			1: return BYTE_SS;
			2: return BYTE_DS;
			3: return BYTE_ES;
			4: return BYTE_FS;
			default: return BYTE_GS;
		endcase
	endfunction

	function automatic logic [1:0] rex_kind();
		return dec_ext[5] ? KIND_REX : KIND_LEGACY;
	endfunction

	task automatic clear_decoder();
		dec_phase = PH_LEAD;
		dec_lock_rep = '0;
		dec_seg = SEG_NONE;
		dec_size = '0;
		dec_ext = '0;
		dec_vec = '0;
		dec_perr = ST_OK;
	endtask

	task automatic post_result(input logic [2:0] st, input logic [7:0] op, input logic [1:0] kd,
			input logic lst);
		xpd_result_t r;
		r.status = st;
		r.opcode = op;
		r.kind = kd;
		r.lock_rep = dec_lock_rep;
		r.seg = dec_seg;
		r.opsz = dec_size[0];
		r.adsz = dec_size[1];
		r.ext = dec_ext[4:0];
		r.map = dec_vec.map;
		r.vreg = dec_vec.vreg;
		r.len_pp = dec_vec.len_pp;
		r.mask = dec_vec.mask;
		prefix_results_q.push_back(r);
		clear_decoder();
		if (!lst) begin
			dec_phase = PH_SKIP;
		end
	endtask

	task automatic decode_legacy_byte(input logic [7:0] b, input logic lst);
		logic [2:0] sc;
		sc = segment_of(b);
		dec_phase = PH_LEGACY;
		if (b == BYTE_LOCK || b == BYTE_REPNE || b == BYTE_REP) begin
			if (dec_lock_rep != '0) begin
				post_result(ST_DUP_LR, 8'h00, rex_kind(), lst);
				return;
			end
			dec_lock_rep = (b == BYTE_LOCK) ? LR_LOCK : (b == BYTE_REPNE) ? LR_REPNE : LR_REP;
		end else if (sc != SEG_NONE) begin
			dec_seg = sc;
		end else if (b == BYTE_OPSZ) begin
			dec_size[0] = 1'b1;
		end else if (b == BYTE_ADSZ) begin
			dec_size[1] = 1'b1;
		end else if ((b & REX_MASK) == REX_BASE) begin
			if (dec_ext[5]) begin
				post_result(ST_DUP_REX, 8'h00, rex_kind(), lst);
				return;
			end
			dec_ext = {1'b1, b[3], 1'b0, b[2:0]};
		end else begin
			post_result(ST_OK, b, rex_kind(), lst);
			return;
		end
		if (lst) begin
			post_result(ST_ENDED, 8'h00, rex_kind(), lst);
		end
	endtask

	task automatic decode_prefix_byte(input logic [7:0] b, input logic lst);
		logic [2:0] sc;
		if (dec_phase != PH_SKIP) begin
			decoded_bytes++;
		end
		case (dec_phase)
			PH_SKIP: begin
				if (lst) begin
					clear_decoder();
				end
			end
			PH_LEGACY: decode_legacy_byte(b, lst);
			PH_VEX2_D: begin
				dec_ext = {3'b000, b[7], 2'b11};
				dec_vec = '0;
				dec_vec.map = 5'd1;
				dec_vec.vreg = {1'b0, b[6:3]};
				dec_vec.len_pp = {1'b0, b[2], b[1:0]};
				dec_phase = PH_VEX_OP;
				if (lst) begin
					post_result(ST_ENDED, 8'h00, KIND_VEX, lst);
				end
			end
			PH_VEX3_D1: begin
				dec_ext = {3'b000, b[7], b[6], b[5]};
				dec_vec = '0;
				dec_vec.map = b[4:0];
				dec_phase = PH_VEX3_D2;
				if (lst) begin
					post_result(ST_VEX_INC, 8'h00, KIND_VEX, lst);
				end
			end
			PH_VEX3_D2: begin
				dec_ext[4] = b[7];
				dec_vec.vreg = {1'b0, b[6:3]};
				dec_vec.len_pp = {1'b0, b[2], b[1:0]};
				dec_phase = PH_VEX_OP;
				if (lst) begin
					post_result(ST_ENDED, 8'h00, KIND_VEX, lst);
				end
			end
			PH_VEX_OP: post_result(ST_OK, b, KIND_VEX, lst);
			PH_EVEX_D1: begin
				dec_ext = {2'b00, b[4], b[7], b[6], b[5]};
				dec_vec = '0;
				dec_vec.map = {3'b000, b[1:0]};
				if (b[3:2] != 2'b00) begin
					dec_perr = ST_EVEX_B1;
				end
				dec_phase = PH_EVEX_D2;
				if (lst) begin
					post_result(ST_EVEX_INC, 8'h00, KIND_EVEX, lst);
				end
			end
			PH_EVEX_D2: begin
				dec_ext[4] = b[7];
				dec_vec.vreg[3:0] = b[6:3];
				dec_vec.len_pp[1:0] = b[1:0];
				if (dec_perr == ST_OK && !b[2]) begin
					dec_perr = ST_EVEX_B2;
				end
				dec_phase = PH_EVEX_D3;
				if (lst) begin
					post_result(ST_EVEX_INC, 8'h00, KIND_EVEX, lst);
				end
			end
			PH_EVEX_D3: begin
				dec_vec.vreg[4] = b[3];
				dec_vec.len_pp[3:2] = b[6:5];
				dec_vec.mask = {b[7], b[4], b[2:0]};
				if (dec_perr != ST_OK) begin
					post_result(dec_perr, 8'h00, KIND_EVEX, lst);
				end else begin
					dec_phase = PH_EVEX_OP;
					if (lst) begin
						post_result(ST_ENDED, 8'h00, KIND_EVEX, lst);
					end
				end
			end
			PH_EVEX_OP: post_result(ST_OK, b, KIND_EVEX, lst);
			default: begin
				dec_phase = PH_LEAD;
				sc = segment_of(b);
				if (sc != SEG_NONE || b == BYTE_ADSZ) begin
					if (sc != SEG_NONE) begin
						dec_seg = sc;
					end else begin
						dec_size[1] = 1'b1;
					end
					if (lst) begin
						post_result(ST_ENDED, 8'h00, KIND_LEGACY, lst);
					end
				end else if (b == BYTE_VEX2 || b == BYTE_VEX3) begin
					dec_phase = (b == BYTE_VEX2) ? PH_VEX2_D : PH_VEX3_D1;
					if (lst) begin
						post_result(ST_VEX_INC, 8'h00, KIND_VEX, lst);
					end
				end else if (b == BYTE_EVEX) begin
					dec_phase = PH_EVEX_D1;
					if (lst) begin
						post_result(ST_EVEX_INC, 8'h00, KIND_EVEX, lst);
					end
				end else begin
					decode_legacy_byte(b, lst);
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch($sformatf("result %0d field %s is %0h, predicted %0h",
				results_checked, name, got, exp_val));
		end
	endtask

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= lst;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_bytes++;
		decode_prefix_byte(b, lst);
	endtask

	// Sends the n low bytes of seq, most significant first, marking the final one last.
	task automatic send_packed(input logic [63:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			send_byte(seq[i*8 +: 8], i == 0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (prefix_results_q.size() == 0) begin
				report_mismatch("result beat arrived with none predicted");
			end else begin
				want = prefix_results_q.pop_front();
				check_field("status", 8'(status), 8'(want.status));
				check_field("opcode_byte", opcode_byte, want.opcode);
				check_field("encoding_kind", 8'(encoding_kind), 8'(want.kind));
				check_field("lock_rep_prefix", 8'(lock_rep_prefix), 8'(want.lock_rep));
				check_field("segment_prefix", 8'(segment_prefix), 8'(want.seg));
				check_field("operand_size_flag", 8'(operand_size_flag), 8'(want.opsz));
				check_field("address_size_flag", 8'(address_size_flag), 8'(want.adsz));
				check_field("extension_bits", 8'(extension_bits), 8'(want.ext));
				check_field("opcode_map", 8'(opcode_map), 8'(want.map));
				check_field("register_specifier", 8'(register_specifier), 8'(want.vreg));
				check_field("length_and_prefix", 8'(length_and_prefix), 8'(want.len_pp));
				check_field("evex_mask_bits", 8'(evex_mask_bits), 8'(want.mask));
				if (want.status != ST_OK) begin
					error_results++;
				end
				results_checked++;
			end
		end
	end

	initial begin : rx_drive
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
				out_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL x86_prefix_decoder_top");
		$finish;
	end

	task automatic test_legacy_prefixes();
		send_packed(64'h00, 1);
		send_packed(64'h2EF3664FFF, 5);
		send_packed(64'hF0F290, 3);
		send_packed(64'h4041, 2);
		send_packed(64'h67, 1);
		send_packed(64'h66C5, 2);
	endtask

	task automatic test_vex_prefixes();
		send_packed(64'hC4E37D1A, 4);
		send_packed(64'hC5FF, 2);
		send_packed(64'hC400, 2);
	endtask

	task automatic test_evex_prefixes();
		send_packed(64'h62F17C4858, 5);
		send_packed(64'h620C00, 3);
		send_packed(64'h62F178FF, 4);
	endtask

	// Results pile up behind a long output hold until the decoder stalls its input.
	task automatic test_output_hold();
		rx_hold_len = HOLD_CYCLES;
		repeat (12) begin
			send_byte(8'($urandom_range(8'h80, 8'h8F)), 1'b1);
		end
	endtask

	task automatic test_random_instructions(input int target);
		logic [7:0] seq [$];
		logic [7:0] b1;
		logic [7:0] b2;
		int start;
		int pick;
		int cut;
		start = sent_bytes;
		while (sent_bytes - start < target) begin
			if (sent_bytes - start > target * 4 / 5) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			seq.delete();
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					seq.push_back(($urandom_range(0, 3) == 0) ? BYTE_ADSZ : pick_segment_byte());
				end
			end
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 6))
						0: seq.push_back(BYTE_LOCK);
						1: seq.push_back(BYTE_REPNE);
						2: seq.push_back(BYTE_REP);
						3: seq.push_back(BYTE_OPSZ);
						4: seq.push_back(BYTE_ADSZ);
						5: seq.push_back(pick_segment_byte());
						default: seq.push_back(REX_BASE | 8'($urandom_range(0, 15)));
					endcase
				end
				case ($urandom_range(0, 7))
					0: seq.push_back(BYTE_VEX2);
					1: seq.push_back(BYTE_VEX3);
					2: seq.push_back(BYTE_EVEX);
					default: seq.push_back(8'($urandom_range(0, 255)));
				endcase
			end else if (pick == 4) begin
				seq.push_back(BYTE_VEX2);
				repeat (2) seq.push_back(8'($urandom_range(0, 255)));
			end else if (pick == 5) begin
				seq.push_back(BYTE_VEX3);
				repeat (3) seq.push_back(8'($urandom_range(0, 255)));
			end else if (pick <= 7) begin
				b1 = 8'($urandom_range(0, 255));
				b2 = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) != 0) begin
					b1[3:2] = 2'b00;
				end
				if ($urandom_range(0, 4) != 0) begin
					b2[2] = 1'b1;
				end
				seq.push_back(BYTE_EVEX);
				seq.push_back(b1);
				seq.push_back(b2);
				repeat (2) seq.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
			end
			repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 255)));
			cut = seq.size() - 1;
			if ($urandom_range(0, 6) == 0) begin
				cut = $urandom_range(0, seq.size() - 1);
			end
			for (int i = 0; i <= cut; i++) begin
				send_byte(seq[i], i == cut);
			end
		end
	endtask

	initial begin : main
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_value = 8'h00;
		last_byte = 1'b0;
		clear_decoder();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_legacy_prefixes();
		test_vex_prefixes();
		test_evex_prefixes();
		test_output_hold();
		test_random_instructions(RANDOM_BYTES);
		in_valid <= 1'b0;
		while (prefix_results_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes, %0d of them decoded, into %0d checked results, %0d errors.",
			sent_bytes, decoded_bytes, results_checked, error_results);
		$display("Covered legacy, REX, VEX and EVEX paths, random idling, and a %0d-cycle hold.",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("PASS x86_prefix_decoder_top");
		end else begin
			$display("FAIL x86_prefix_decoder_top");
		end
		$finish;
	end

endmodule

>>> x86_prefix_decoder_top.f
+incdir+design
design/xpd_pkg.sv
design/xpd_step.sv
design/x86_prefix_decoder_top.sv
dv/tb_top.sv
